// ===== rtl/core/erx_pkg.sv =====
// Shared types, constants and helpers of the Ethernet receive address and type filter.
package erx_pkg;

    localparam int MAC_W   = 48;
    localparam int TYPE_W  = 16;
    localparam int COUNT_W = 11;
    localparam int LEN_W   = COUNT_W + 1;
    localparam int PLEN_W  = 11;

    localparam logic [LEN_W-1:0] HEADER_BYTES    = 12'd14;
    localparam logic [LEN_W-1:0] MAX_FRAME_BYTES = 12'd1514;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] DEST_END    = 11'd6;
    localparam logic [COUNT_W-1:0] SRC_END     = 11'd12;
    localparam logic [COUNT_W-1:0] TYPE_HI_POS = 11'd12;
    localparam logic [COUNT_W-1:0] TYPE_LO_POS = 11'd13;
    localparam logic [7:0]         BROADCAST_BYTE = 8'hFF;

    localparam logic [MAC_W-1:0]  OWN_MAC_RESET   = 48'h0;
    localparam logic [TYPE_W-1:0] CHAT_TYPE_RESET = 16'h2080;
    localparam logic [TYPE_W-1:0] FILE_TYPE_RESET = 16'h2090;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_OWN_MAC   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHAT_TYPE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FILE_TYPE = 2'd2;

    typedef enum logic [2:0] {
        ST_ACCEPTED     = 3'd0,
        ST_BAD_LENGTH   = 3'd1,
        ST_NOT_FOR_US   = 3'd2,
        ST_OWN_ECHO     = 3'd3,
        ST_UNKNOWN_TYPE = 3'd4
    } erx_status_t;

    typedef struct packed {
        logic [LEN_W-1:0]  frame_len;
        logic              dest_is_own;
        logic              dest_is_broadcast;
        logic              source_is_own;
        logic [MAC_W-1:0]  source;
        logic [TYPE_W-1:0] ethertype;
    } erx_frame_t;

    typedef struct packed {
        erx_status_t       status;
        logic              app_class;
        logic [PLEN_W-1:0] payload_length;
        logic [MAC_W-1:0]  source_mac;
    } erx_result_t;

    function automatic logic [7:0] erx_own_byte(input logic [MAC_W-1:0] mac,
                                                input logic [2:0] k);
        logic [7:0] b;
        unique case (k)
            3'd0:    b = mac[47:40];
            3'd1:    b = mac[39:32];
            3'd2:    b = mac[31:24];
            3'd3:    b = mac[23:16];
            3'd4:    b = mac[15:8];
            3'd5:    b = mac[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [MAC_W-1:0] erx_place_byte(input logic [7:0] b,
                                                        input logic [2:0] k);
        logic [MAC_W-1:0] w;
        w = '0;
        unique case (k)
            3'd0:    w[47:40] = b;
            3'd1:    w[39:32] = b;
            3'd2:    w[31:24] = b;
            3'd3:    w[23:16] = b;
            3'd4:    w[15:8]  = b;
            3'd5:    w[7:0]   = b;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/ethernet_rx_address_type_filter_top.sv =====
// Top level of the Ethernet receive address and type filter.
//
// Input stream: one frame byte per transaction on s_tdata, header first, with
// s_tlast on the final byte. Output stream: one verdict transaction per frame,
// status and class on m_tuser, payload length and source address on m_tdata.
// Configuration: cfg_we writes cfg_wdata into register cfg_index at the clock
// edge (0 station address, 1 chat EtherType, 2 file EtherType).
//
// Throughput is one byte per cycle while s_tready is high. The verdict is computed
// in the cycle the last byte is accepted and is registered in the result buffer
// before it appears on m_tvalid, behind any verdict still waiting there.
//
// When the receiver stalls, a second result entry absorbs one more verdict;
// s_tready drops only once both entries are full, and rises again as soon as
// one verdict is taken.
//
// Reset clears the frame state, empties both result entries, and loads the
// station address with zero and the EtherType registers with 0x2080 and 0x2090.
module ethernet_rx_address_type_filter_top
    import erx_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] data_byte
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [63:0]            m_tdata,   // [10:0] payload_length, [58:11] source_mac
    output logic [3:0]             m_tuser,   // [2:0] status, [3] app_class
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [MAC_W-1:0]       cfg_wdata
);

    logic [MAC_W-1:0]  own_mac_reg, own_mac_next;
    logic [TYPE_W-1:0] chat_type_reg, chat_type_next;
    logic [TYPE_W-1:0] file_type_reg, file_type_next;
    logic              accept;
    erx_frame_t        frame;
    erx_result_t       result;
    erx_result_t       out_result;

    always_comb
    begin
        own_mac_next   = own_mac_reg;
        chat_type_next = chat_type_reg;
        file_type_next = file_type_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OWN_MAC:   own_mac_next   = cfg_wdata;
                REG_CHAT_TYPE: chat_type_next = cfg_wdata[TYPE_W-1:0];
                REG_FILE_TYPE: file_type_next = cfg_wdata[TYPE_W-1:0];
                default:       own_mac_next   = own_mac_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg   <= OWN_MAC_RESET;
            chat_type_reg <= CHAT_TYPE_RESET;
            file_type_reg <= FILE_TYPE_RESET;
        end
        else
        begin
            own_mac_reg   <= own_mac_next;
            chat_type_reg <= chat_type_next;
            file_type_reg <= file_type_next;
        end
    end

    assign accept = s_tvalid && s_tready;

    erx_frame_track u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .own_mac   (own_mac_reg),
        .frame     (frame)
    );

    erx_verdict u_verdict (
        .frame          (frame),
        .chat_ethertype (chat_type_reg),
        .file_ethertype (file_type_reg),
        .result         (result)
    );

    erx_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid && s_tlast),
        .in_ready  (s_tready),
        .in_data   (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {5'b0, out_result.source_mac, out_result.payload_length};
    assign m_tuser = {out_result.app_class, out_result.status};

endmodule

// ===== rtl/core/erx_frame_track.sv =====
// Per-frame byte counter, address match flags and source and EtherType capture.
module erx_frame_track
    import erx_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    input  logic [MAC_W-1:0] own_mac,
    output erx_frame_t       frame
);

    logic [COUNT_W-1:0] count_reg, count_next;
    logic               dest_own_reg, dest_own_next, dest_own_upd;
    logic               dest_bc_reg, dest_bc_next, dest_bc_upd;
    logic               src_own_reg, src_own_next, src_own_upd;
    logic [MAC_W-1:0]   source_reg, source_next, source_upd;
    logic [TYPE_W-1:0]  type_reg, type_next, type_upd;
    logic [3:0]         src_pos;

    always_comb
    begin
        dest_own_upd = dest_own_reg;
        dest_bc_upd  = dest_bc_reg;
        src_own_upd  = src_own_reg;
        source_upd   = source_reg;
        type_upd     = type_reg;
        src_pos      = count_reg[3:0] - 4'd6;

        if (count_reg < DEST_END)
        begin
            if (data_byte != erx_own_byte(own_mac, count_reg[2:0]))
            begin
                dest_own_upd = 1'b0;
            end
            if (data_byte != BROADCAST_BYTE)
            begin
                dest_bc_upd = 1'b0;
            end
        end
        else if (count_reg < SRC_END)
        begin
            if (data_byte != erx_own_byte(own_mac, src_pos[2:0]))
            begin
                src_own_upd = 1'b0;
            end
            source_upd = source_reg | erx_place_byte(data_byte, src_pos[2:0]);
        end
        else if (count_reg == TYPE_HI_POS)
        begin
            type_upd = type_reg | {data_byte, 8'h00};
        end
        else if (count_reg == TYPE_LO_POS)
        begin
            type_upd = type_reg | {8'h00, data_byte};
        end

        frame.frame_len         = {1'b0, count_reg} + 12'd1;
        frame.dest_is_own       = dest_own_upd;
        frame.dest_is_broadcast = dest_bc_upd;
        frame.source_is_own     = src_own_upd;
        frame.source            = source_upd;
        frame.ethertype         = type_upd;

        count_next    = count_reg;
        dest_own_next = dest_own_reg;
        dest_bc_next  = dest_bc_reg;
        src_own_next  = src_own_reg;
        source_next   = source_reg;
        type_next     = type_reg;

        if (accept)
        begin
            if (last_byte)
            begin
                count_next    = '0;
                dest_own_next = 1'b1;
                dest_bc_next  = 1'b1;
                src_own_next  = 1'b1;
                source_next   = '0;
                type_next     = '0;
            end
            else
            begin
                count_next    = (count_reg != COUNT_MAX) ? count_reg + 11'd1 : count_reg;
                dest_own_next = dest_own_upd;
                dest_bc_next  = dest_bc_upd;
                src_own_next  = src_own_upd;
                source_next   = source_upd;
                type_next     = type_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            dest_own_reg <= 1'b1;
            dest_bc_reg  <= 1'b1;
            src_own_reg  <= 1'b1;
            source_reg   <= '0;
            type_reg     <= '0;
        end
        else
        begin
            count_reg    <= count_next;
            dest_own_reg <= dest_own_next;
            dest_bc_reg  <= dest_bc_next;
            src_own_reg  <= src_own_next;
            source_reg   <= source_next;
            type_reg     <= type_next;
        end
    end

endmodule

// ===== rtl/core/erx_verdict.sv =====
// Frame verdict: length, destination, echo and EtherType checks in priority order.
module erx_verdict
    import erx_pkg::*;
(
    input  erx_frame_t        frame,
    input  logic [TYPE_W-1:0] chat_ethertype,
    input  logic [TYPE_W-1:0] file_ethertype,
    output erx_result_t       result
);

    logic [LEN_W-1:0] plen_full;

    always_comb
    begin
        plen_full             = frame.frame_len - HEADER_BYTES;
        result.status         = ST_ACCEPTED;
        result.app_class      = 1'b0;
        result.payload_length = '0;
        result.source_mac     = frame.source;

        priority if (frame.frame_len < HEADER_BYTES || frame.frame_len > MAX_FRAME_BYTES)
        begin
            result.status = ST_BAD_LENGTH;
        end
        else if (!frame.dest_is_own && !frame.dest_is_broadcast)
        begin
            result.status = ST_NOT_FOR_US;
        end
        else if (frame.source_is_own)
        begin
            result.status = ST_OWN_ECHO;
        end
        else if (frame.ethertype == chat_ethertype)
        begin
            result.payload_length = plen_full[PLEN_W-1:0];
        end
        else if (frame.ethertype == file_ethertype)
        begin
            result.app_class      = 1'b1;
            result.payload_length = plen_full[PLEN_W-1:0];
        end
        else
        begin
            result.status = ST_UNKNOWN_TYPE;
        end
    end

endmodule

// ===== rtl/core/erx_out_buf.sv =====
// Two-entry result register with skid stage between verdict logic and output channel.
module erx_out_buf
    import erx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  erx_result_t in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output erx_result_t out_data
);

    logic        main_valid_reg, main_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    erx_result_t main_data_reg, main_data_next;
    erx_result_t skid_data_reg, skid_data_next;
    logic        push;
    logic        pop;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_comb
    begin
        push            = in_valid && !skid_valid_reg;
        pop             = main_valid_reg && out_ready;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;

        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = 1'b0;
            end
        end

        if (push)
        begin
            if (!main_valid_next)
            begin
                main_valid_next = 1'b1;
                main_data_next  = in_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = in_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ===== tb/ethernet_rx_address_type_filter_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the Ethernet receive address and type filter top level.
module ethernet_rx_address_type_filter_top_test;
    import erx_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 4;
    localparam int RANDOM_BYTES_PER_PHASE = 50;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = '0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [63:0]            m_tdata;
    logic [3:0]             m_tuser;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_OWN_MAC;
    logic [MAC_W-1:0]       cfg_wdata = '0;

    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          rx_hold_cycles = 0;
    int unsigned bytes_offered = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    logic [MAC_W-1:0]   station_mac = OWN_MAC_RESET;
    logic [TYPE_W-1:0]  chat_type = CHAT_TYPE_RESET;
    logic [TYPE_W-1:0]  file_type = FILE_TYPE_RESET;
    logic [COUNT_W-1:0] frame_pos = '0;
    logic               dest_match_own = 1'b1;
    logic               dest_match_bcast = 1'b1;
    logic               src_match_own = 1'b1;
    logic [MAC_W-1:0]   src_capture = '0;
    logic [TYPE_W-1:0]  type_capture = '0;

    erx_result_t pending_verdicts[$];
    logic [7:0]  frame_buf[$];

    ethernet_rx_address_type_filter_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    function automatic void clear_frame_state();
        frame_pos = '0;
        dest_match_own = 1'b1;
        dest_match_bcast = 1'b1;
        src_match_own = 1'b1;
        src_capture = '0;
        type_capture = '0;
    endfunction

    function automatic void filter_byte(input logic [7:0] b, input logic last);
        int          pos;
        int          flen;
        erx_result_t v;
        pos = int'(frame_pos);
        if (pos < 6)
        begin
            if (b != station_mac[(5 - pos) * 8 +: 8])
                dest_match_own = 1'b0;
            if (b != BROADCAST_BYTE)
                dest_match_bcast = 1'b0;
        end
        else if (pos < 12)
        begin
            if (b != station_mac[(11 - pos) * 8 +: 8])
                src_match_own = 1'b0;
            src_capture[(11 - pos) * 8 +: 8] = b;
        end
        else if (pos == 12)
            type_capture[15:8] = b;
        else if (pos == 13)
            type_capture[7:0] = b;
        if (frame_pos != COUNT_MAX)
            frame_pos = frame_pos + 1'b1;
        if (last)
        begin
            flen = pos + 1;
            v.status = ST_ACCEPTED;
            v.app_class = 1'b0;
            v.payload_length = '0;
            v.source_mac = src_capture;
            if (flen < int'(HEADER_BYTES) || flen > int'(MAX_FRAME_BYTES))
                v.status = ST_BAD_LENGTH;
            else if (!dest_match_own && !dest_match_bcast)
                v.status = ST_NOT_FOR_US;
            else if (src_match_own)
                v.status = ST_OWN_ECHO;
            else if (type_capture == chat_type)
                v.payload_length = PLEN_W'(flen - int'(HEADER_BYTES));
            else if (type_capture == file_type)
            begin
                v.app_class = 1'b1;
                v.payload_length = PLEN_W'(flen - int'(HEADER_BYTES));
            end
            else
                v.status = ST_UNKNOWN_TYPE;
            pending_verdicts.push_back(v);
            clear_frame_state();
        end
    endfunction

    function automatic void report_field(input string field, input logic [63:0] want,
                                         input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_verdict();
        erx_result_t want;
        if (pending_verdicts.size() == 0)
        begin
            $display("%0t: verdict expected none actual status %0h source %0h", $time,
                     m_tuser[2:0], m_tdata[58:11]);
            mismatches++;
        end
        else
        begin
            want = pending_verdicts.pop_front();
            report_field("status", 64'(want.status), 64'(m_tuser[2:0]));
            report_field("app_class", 64'(want.app_class), 64'(m_tuser[3]));
            report_field("payload_length", 64'(want.payload_length), 64'(m_tdata[10:0]));
            report_field("source_mac", 64'(want.source_mac), 64'(m_tdata[58:11]));
        end
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            station_mac = OWN_MAC_RESET;
            chat_type = CHAT_TYPE_RESET;
            file_type = FILE_TYPE_RESET;
            clear_frame_state();
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_verdict();
            if (s_tvalid && s_tready)
                filter_byte(s_tdata, s_tlast);
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_OWN_MAC:   station_mac = cfg_wdata;
                    REG_CHAT_TYPE: chat_type = cfg_wdata[TYPE_W-1:0];
                    REG_FILE_TYPE: file_type = cfg_wdata[TYPE_W-1:0];
                    default:       ;
                endcase
            end
        end
    end

    always @(negedge clk)
    begin
        if (rx_hold_cycles > 0)
        begin
            m_tready <= 1'b0;
            rx_hold_cycles <= rx_hold_cycles - 1;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("ethernet_rx_address_type_filter_top_test NOT OK");
        $finish;
    end

    function automatic logic [MAC_W-1:0] rand_mac();
        return 48'({$urandom, $urandom});
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        bytes_offered++;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic void build_frame(input logic [MAC_W-1:0] dest, input logic [MAC_W-1:0] src,
                                        input logic [TYPE_W-1:0] etype, input int len);
        frame_buf.delete();
        for (int i = 0; i < len; i++)
        begin
            if (i < 6)
                frame_buf.push_back(dest[(5 - i) * 8 +: 8]);
            else if (i < 12)
                frame_buf.push_back(src[(11 - i) * 8 +: 8]);
            else if (i == 12)
                frame_buf.push_back(etype[15:8]);
            else if (i == 13)
                frame_buf.push_back(etype[7:0]);
            else
                frame_buf.push_back(8'($urandom));
        end
    endfunction

    task automatic send_range(input int first, input int stop);
        for (int i = first; i < stop; i++)
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    task automatic send_frame(input logic [MAC_W-1:0] dest, input logic [MAC_W-1:0] src,
                              input logic [TYPE_W-1:0] etype, input int len);
        build_frame(dest, src, etype, len);
        send_range(0, len);
    endtask

    task automatic drain_verdicts();
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [MAC_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_config(input logic [MAC_W-1:0] mac, input logic [TYPE_W-1:0] chat,
                              input logic [TYPE_W-1:0] file);
        drain_verdicts();
        write_reg(REG_OWN_MAC, mac);
        write_reg(REG_CHAT_TYPE, {$urandom, chat});
        write_reg(REG_FILE_TYPE, {$urandom, file});
    endtask

    task automatic send_random_frame();
        int               r;
        int               len;
        logic [MAC_W-1:0] dest;
        logic [MAC_W-1:0] src;
        logic [TYPE_W-1:0] etype;
        r = $urandom_range(0, 99);
        if (r < 45)
            dest = station_mac;
        else if (r < 70)
            dest = '1;
        else if (r < 90)
            dest = rand_mac();
        else
        begin
            dest = station_mac;
            dest[$urandom_range(0, 47)] ^= 1'b1;
        end
        r = $urandom_range(0, 99);
        if (r < 75)
            src = rand_mac();
        else if (r < 90)
            src = station_mac;
        else
        begin
            src = station_mac;
            src[$urandom_range(0, 47)] ^= 1'b1;
        end
        r = $urandom_range(0, 99);
        if (r < 40)
            etype = chat_type;
        else if (r < 70)
            etype = file_type;
        else if (r < 90)
            etype = 16'($urandom);
        else
        begin
            etype = chat_type;
            etype[$urandom_range(0, 15)] ^= 1'b1;
        end
        if ($urandom_range(0, 99) < 10)
            len = $urandom_range(1, 13);
        else
            len = $urandom_range(14, 40);
        send_frame(dest, src, etype, len);
    endtask

    task automatic test_reset_defaults();
        send_idle_pct = 0;
        stall_pct = 0;
        send_frame(48'h0, rand_mac(), CHAT_TYPE_RESET, 20);
        send_frame('1, rand_mac(), FILE_TYPE_RESET, 60);
        send_frame('1, rand_mac(), 16'h0800, 30);
        send_frame('1, 48'h0, CHAT_TYPE_RESET, 14);
        drain_verdicts();
        write_reg(REG_UNUSED, '1);
        send_frame(48'h0, rand_mac(), CHAT_TYPE_RESET, 15);
    endtask

    task automatic test_frame_lengths();
        logic [MAC_W-1:0] mac;
        logic [MAC_W-1:0] src;
        mac = rand_mac();
        src = rand_mac();
        set_config(mac, 16'h0000, 16'hFFFF);
        send_frame(mac, src, 16'h0000, 1);
        send_frame(mac, src, 16'h0000, 9);
        send_frame(mac, src, 16'h0000, int'(HEADER_BYTES) - 1);
        send_frame(mac, src, 16'h0000, int'(HEADER_BYTES));
        send_frame(mac, src, 16'h0000, 20);
    endtask

    task automatic test_verdict_order();
        logic [MAC_W-1:0] mac;
        mac = rand_mac();
        set_config(mac, 16'h88B5, 16'h88B6);
        send_frame(rand_mac(), rand_mac(), 16'h88B5, 30);
        send_frame(mac ^ 48'h1, rand_mac(), 16'h88B5, 30);
        send_frame(mac, mac, 16'h88B5, 30);
        send_frame(mac, mac ^ 48'h1, 16'h88B6, 30);
        send_frame(mac, rand_mac(), 16'h1234, 30);
        send_frame(rand_mac(), mac, 16'hDEAD, 12);
        send_frame(rand_mac(), mac, 16'h88B5, 20);
        send_frame('1, mac, 16'hDEAD, 20);
        // equal type registers: chat wins
        set_config(mac, 16'h1234, 16'h1234);
        send_frame(mac, rand_mac(), 16'h1234, 25);
        // station address is broadcast
        set_config('1, 16'h88B5, 16'h88B6);
        send_frame('1, rand_mac(), 16'h88B6, 40);
        send_frame('1, '1, 16'h88B5, 20);
    endtask

    task automatic test_write_inside_frame();
        logic [MAC_W-1:0] old_mac;
        logic [MAC_W-1:0] new_mac;
        old_mac = rand_mac();
        new_mac = rand_mac();
        set_config(old_mac, 16'h88B5, 16'h88B6);
        build_frame({old_mac[47:24], new_mac[23:0]}, rand_mac(), 16'h4321, 24);
        send_range(0, 3);
        drain_verdicts();
        write_reg(REG_OWN_MAC, new_mac);
        send_range(3, 16);
        drain_verdicts();
        write_reg(REG_CHAT_TYPE, {$urandom, 16'h4321});
        send_range(16, 24);
    endtask

    task automatic test_receiver_hold();
        set_config(rand_mac(), 16'h2080, 16'h2090);
        send_idle_pct = 0;
        stall_pct = 0;
        rx_hold_cycles = 300;
        repeat (12)
            send_frame(station_mac, rand_mac(), chat_type, int'(HEADER_BYTES) + $urandom_range(0, 4));
        drain_verdicts();
    endtask

    task automatic test_random_traffic(input int idle, input int stall, input logic [MAC_W-1:0] mac,
                                       input logic [TYPE_W-1:0] chat, input logic [TYPE_W-1:0] file);
        int unsigned stop;
        set_config(mac, chat, file);
        send_idle_pct = idle;
        stall_pct = stall;
        stop = bytes_offered + RANDOM_BYTES_PER_PHASE;
        while (bytes_offered < stop)
            send_random_frame();
        drain_verdicts();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_reset_defaults();
        test_frame_lengths();
        test_verdict_order();
        test_write_inside_frame();
        test_receiver_hold();
        test_random_traffic(0, 0, rand_mac(), 16'h0000, 16'hFFFF);
        test_random_traffic(68, 0, rand_mac(), 16'($urandom), 16'($urandom));
        test_random_traffic(0, 68, '1, CHAT_TYPE_RESET, FILE_TYPE_RESET);
        test_random_traffic(38, 38, 48'h0, 16'hFFFF, 16'h0000);
        drain_verdicts();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("ethernet_rx_address_type_filter_top_test OK");
        else
            $display("ethernet_rx_address_type_filter_top_test NOT OK");
        $finish;
    end

endmodule
